@@ sv/cswc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswc_pkg: shared types and constants for the whitespace compactor
// Holds the lexical mode encoding, the character codes the lexer looks for,
// the result entry format and the result buffer dimensions.
// ----------------------------------------------------------------------------
package cswc_pkg;

  // Lexical modes of the scanner.
  typedef enum logic [2:0] {
    MODE_CODE    = 3'd0,
    MODE_STR     = 3'd1,
    MODE_CHR     = 3'd2,
    MODE_STR_ESC = 3'd3,
    MODE_CHR_ESC = 3'd4
  } mode_e;

  // Characters of interest.
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Result buffer dimensions.
  localparam int unsigned BufDepth = 4;
  localparam int unsigned PtrW     = 2;
  localparam int unsigned CntW     = 3;

  // One result as held in the buffer.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } entry_t;

  // Results produced by one transfer: count, then up to two bytes.
  // With one result it is in first_byte; with two, first_byte is the space.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } push_t;

  // Whitespace test: HT, LF, VT, FF, CR or space.
  function automatic logic is_ws(input logic [7:0] c);
    is_ws = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

endpackage

@@ sv/cswc_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswc_lexer: lexical state and result decode
// Tracks code, literal and escape modes, header-line mode and the pending
// space, and decodes each accepted byte into zero, one or two results.
// ----------------------------------------------------------------------------
module cswc_lexer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          in_byte_i,
  output cswc_pkg::push_t     push_o
);

  cswc_pkg::mode_e mode_q, mode_d;
  logic            hdr_q, hdr_d;
  logic            sp_q, sp_d;

  // Next state of the scanner.
  always_comb begin
    mode_d = mode_q;
    hdr_d  = hdr_q;
    sp_d   = sp_q;
    if (take_i) begin
      unique case (mode_q)
        cswc_pkg::MODE_STR: begin
          if (in_byte_i == cswc_pkg::CH_BSLASH) begin
            mode_d = cswc_pkg::MODE_STR_ESC;
          end else if (in_byte_i == cswc_pkg::CH_DQUOTE || in_byte_i == cswc_pkg::CH_NL) begin
            mode_d = cswc_pkg::MODE_CODE;
          end
        end
        cswc_pkg::MODE_CHR: begin
          if (in_byte_i == cswc_pkg::CH_BSLASH) begin
            mode_d = cswc_pkg::MODE_CHR_ESC;
          end else if (in_byte_i == cswc_pkg::CH_SQUOTE || in_byte_i == cswc_pkg::CH_NL) begin
            mode_d = cswc_pkg::MODE_CODE;
          end
        end
        cswc_pkg::MODE_STR_ESC: mode_d = cswc_pkg::MODE_STR;
        cswc_pkg::MODE_CHR_ESC: mode_d = cswc_pkg::MODE_CHR;
        default: begin
          mode_d = cswc_pkg::MODE_CODE;
          if (in_byte_i == cswc_pkg::CH_HASH) begin
            hdr_d = 1'b1;
          end
          if (cswc_pkg::is_ws(in_byte_i)) begin
            if (hdr_q && in_byte_i == cswc_pkg::CH_NL) begin
              hdr_d = 1'b0;
              sp_d  = 1'b0;
            end else begin
              sp_d = 1'b1;
            end
          end else begin
            sp_d = 1'b0;
            if (in_byte_i == cswc_pkg::CH_DQUOTE) begin
              mode_d = cswc_pkg::MODE_STR;
            end else if (in_byte_i == cswc_pkg::CH_SQUOTE) begin
              mode_d = cswc_pkg::MODE_CHR;
            end
          end
        end
      endcase
    end
  end

  // Results caused by the byte on offer.
  always_comb begin
    push_o.count       = 2'd0;
    push_o.first_byte  = in_byte_i;
    push_o.second_byte = in_byte_i;
    if (take_i) begin
      unique case (mode_q)
        cswc_pkg::MODE_STR, cswc_pkg::MODE_CHR,
        cswc_pkg::MODE_STR_ESC, cswc_pkg::MODE_CHR_ESC: begin
          push_o.count = 2'd1;
        end
        default: begin
          if (cswc_pkg::is_ws(in_byte_i)) begin
            // Only a header-line newline is emitted; other whitespace is held back.
            if (hdr_q && in_byte_i == cswc_pkg::CH_NL) begin
              push_o.count = 2'd1;
            end
          end else if (sp_q) begin
            push_o.count      = 2'd2;
            push_o.first_byte = cswc_pkg::CH_SPACE;
          end else begin
            push_o.count = 2'd1;
          end
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cswc_pkg::MODE_CODE;
      hdr_q  <= 1'b0;
      sp_q   <= 1'b0;
    end else begin
      mode_q <= mode_d;
      hdr_q  <= hdr_d;
      sp_q   <= sp_d;
    end
  end

  // A double emission only flushes a pending space from code mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (sp_q && mode_q == cswc_pkg::MODE_CODE))
    else $error("cswc_lexer: double emission without a pending space");

  // The byte after a backslash is always passed on its own.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && (mode_q == cswc_pkg::MODE_STR_ESC || mode_q == cswc_pkg::MODE_CHR_ESC))
    |-> (push_o.count == 2'd1))
    else $error("cswc_lexer: escaped byte not passed alone");

  // The pending space is cleared once a transfer has emitted it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |=> !sp_q)
    else $error("cswc_lexer: pending space survived its emission");

endmodule

@@ sv/cswc_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswc_out_buf: result buffer
// A four-entry queue that takes up to two results per cycle while two entries
// are free and hands out one per transfer, so input and output stalls are decoupled.
// ----------------------------------------------------------------------------
module cswc_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cswc_pkg::push_t   push_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o
);

  cswc_pkg::entry_t                 mem_q [cswc_pkg::BufDepth];
  logic [cswc_pkg::PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [cswc_pkg::PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [cswc_pkg::CntW-1:0]        count_q, count_d;
  logic                             pop;
  logic [cswc_pkg::PtrW-1:0]        wr_ptr_nxt;

  // Handshake with the receiver and room for a double result.
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign full_o      = (count_q > cswc_pkg::CntW'(cswc_pkg::BufDepth - 2));
  assign wr_ptr_nxt  = wr_ptr_q + 1'b1;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q + cswc_pkg::PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + cswc_pkg::PtrW'(pop);
    count_d  = count_q + cswc_pkg::CntW'(push_i.count) - cswc_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage: the final result of a transfer carries the last flag.
  always_ff @(posedge clk_i) begin
    if (push_i.count == 2'd1) begin
      mem_q[wr_ptr_q] <= '{out_byte: push_i.first_byte, last_of_run: 1'b1};
    end else if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q]   <= '{out_byte: push_i.first_byte, last_of_run: 1'b0};
      mem_q[wr_ptr_nxt] <= '{out_byte: push_i.second_byte, last_of_run: 1'b1};
    end
  end

  assign out_byte_o    = mem_q[rd_ptr_q].out_byte;
  assign last_of_run_o = mem_q[rd_ptr_q].last_of_run;

  // The fill count never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cswc_pkg::CntW'(cswc_pkg::BufDepth))
    else $error("cswc_out_buf: overflow");

  // Results only arrive while there is room for two of them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> !full_o)
    else $error("cswc_out_buf: write while full");

  // The fill count follows pushes and pops exactly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) + cswc_pkg::CntW'($past(push_i.count))
              - cswc_pkg::CntW'($past(pop))))
    else $error("cswc_out_buf: fill count mismatch");

  // Pointers stay a fill count apart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == cswc_pkg::PtrW'(count_q))
    else $error("cswc_out_buf: pointers disagree with fill count");

endmodule

@@ sv/c_source_whitespace_compactor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_source_whitespace_compactor: top level
// Collapses whitespace runs in C source outside literals into single spaces; a newline ending a header line is kept.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one source byte per transfer.
//   Output channel: out_valid_o / out_stall_i carry one result per transfer;
//   last_of_run_o marks the final result caused by an input byte.
//   Each input byte yields zero, one or two results. The lexer decodes the
//   byte in the cycle of its transfer and writes the results into a
//   four-entry buffer, from which they are offered in order. Throughput is
//   one byte per cycle while the receiver does not stall: a double result
//   always follows a byte that gave none, and the buffer absorbs it. The
//   input is stalled while fewer than two buffer entries are free, which
//   happens only when the receiver stalls.
//   Reset puts the scanner in code mode with no pending space and empties
//   the buffer. A space still pending at the end of the input is never
//   emitted.
// ----------------------------------------------------------------------------
module c_source_whitespace_compactor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  cswc_pkg::push_t push;
  logic            full;
  logic            take;

  // An input transfer happens when the buffer has room.
  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  cswc_lexer u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_byte_i (in_byte_i),
    .push_o    (push)
  );

  cswc_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

@@ tb/c_source_whitespace_compactor_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_source_whitespace_compactor_test: self-checking bench for the compactor
// Feeds directed corner cases and then random, mostly C-like byte streams
// through the input channel, with random gaps and stalls on both sides.
// A bit-level predictor of the lexer works out the results of each input
// transfer, and every output transfer is checked against the oldest of them.
// ----------------------------------------------------------------------------
module c_source_whitespace_compactor_test;

  // One source byte waiting to be sent. When hold is set, the sender first
  // waits until every result already due has been received.
  typedef struct {
    logic [7:0] value;
    bit         hold;
  } src_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;

  src_item_t          src_q[$];
  cswc_pkg::entry_t   due_q[$];
  int                 src_n;
  int                 accepted_n;
  int                 err_n;
  logic               drained;
  logic               calm;

  // Predictor state.
  cswc_pkg::mode_e    lex_mode;
  logic               header_line;
  logic               space_owed;

  c_source_whitespace_compactor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .in_byte_i     (in_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_o    (out_byte),
    .last_of_run_o (out_last)
  );

  // Clock and a single reset at the start of the run.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // A stretch of transfers in which neither side idles.
  assign calm = (accepted_n >= 1000) && (accepted_n < 1400);

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_n++;
  endtask

  function automatic logic is_blank(input logic [7:0] c);
    return ((c >= 8'h09) && (c <= 8'h0D)) || (c == cswc_pkg::CH_SPACE);
  endfunction

  // Works out the results of one input byte and queues them in order.
  task automatic predict_compaction(input logic [7:0] c);
    logic [7:0]       emitted[$];
    cswc_pkg::entry_t e;
    unique case (lex_mode)
      cswc_pkg::MODE_STR, cswc_pkg::MODE_CHR: begin
        emitted.push_back(c);
        if (c == cswc_pkg::CH_BSLASH) begin
          lex_mode = (lex_mode == cswc_pkg::MODE_STR) ? cswc_pkg::MODE_STR_ESC
                                                      : cswc_pkg::MODE_CHR_ESC;
        end else if (c == cswc_pkg::CH_NL ||
                     c == ((lex_mode == cswc_pkg::MODE_STR) ? cswc_pkg::CH_DQUOTE
                                                            : cswc_pkg::CH_SQUOTE)) begin
          lex_mode = cswc_pkg::MODE_CODE;
        end
      end
      cswc_pkg::MODE_STR_ESC: begin
        emitted.push_back(c);
        lex_mode = cswc_pkg::MODE_STR;
      end
      cswc_pkg::MODE_CHR_ESC: begin
        emitted.push_back(c);
        lex_mode = cswc_pkg::MODE_CHR;
      end
      default: begin
        lex_mode = cswc_pkg::MODE_CODE;
        if (c == cswc_pkg::CH_HASH) header_line = 1'b1;
        if (is_blank(c)) begin
          // A newline ends a header line and is kept; other blanks collapse.
          if (header_line && c == cswc_pkg::CH_NL) begin
            header_line = 1'b0;
            space_owed  = 1'b0;
            emitted.push_back(c);
          end else begin
            space_owed = 1'b1;
          end
        end else begin
          if (space_owed) begin
            emitted.push_back(cswc_pkg::CH_SPACE);
            space_owed = 1'b0;
          end
          if (c == cswc_pkg::CH_DQUOTE) lex_mode = cswc_pkg::MODE_STR;
          else if (c == cswc_pkg::CH_SQUOTE) lex_mode = cswc_pkg::MODE_CHR;
          emitted.push_back(c);
        end
      end
    endcase
    foreach (emitted[i]) begin
      e.out_byte    = emitted[i];
      e.last_of_run = (i == emitted.size() - 1);
      due_q.push_back(e);
    end
  endtask

  // Driver: offers the next byte, holding it steady while stalled.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic sent;
    logic gap;
    logic next_valid;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_byte  <= 8'h00;
    end else begin
      sent = in_valid && !in_stall;
      if (!in_valid || sent) begin
        gap        = !calm && ($urandom_range(99) < 20);
        next_valid = 1'b0;
        if (src_q.size() > 0 && !gap &&
            !(src_q[0].hold && (!drained || sent))) begin
          in_byte    <= src_q[0].value;
          next_valid = 1'b1;
          void'(src_q.pop_front());
        end
        in_valid <= next_valid;
      end
    end
  end

  // Monitor: checks each output transfer, then predicts from the input one.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    cswc_pkg::entry_t want;
    if (!rst_ni) begin
      out_stall   <= 1'b0;
      drained     <= 1'b1;
      accepted_n  <= 0;
      lex_mode    = cswc_pkg::MODE_CODE;
      header_line = 1'b0;
      space_owed  = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h last %0b",
                                    out_byte, out_last));
        end else begin
          want = due_q.pop_front();
          if (out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                      out_byte, want.out_byte));
          if (out_last !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, wanted %0b (byte %02h)",
                                      out_last, want.last_of_run, want.out_byte));
        end
      end
      if (in_valid && !in_stall) begin
        predict_compaction(in_byte);
        accepted_n <= accepted_n + 1;
      end
      drained   <= (due_q.size() == 0);
      out_stall <= !calm && ($urandom_range(99) < 20);
    end
  end

  // Stimulus helpers. A few chosen bytes wait for the output to drain first.
  task automatic add_byte(input logic [7:0] b);
    src_item_t it;
    it.value = b;
    it.hold  = (src_n == 25) || (src_n == 700) || (src_n == 1500);
    src_q.push_back(it);
    src_n++;
  endtask

  // Printable byte that has no special meaning to the lexer.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'h7E));
    while (c == cswc_pkg::CH_HASH || c == cswc_pkg::CH_DQUOTE ||
           c == cswc_pkg::CH_SQUOTE || c == cswc_pkg::CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] blank_char(input bit allow_nl);
    logic [7:0] c;
    do c = ($urandom_range(5) == 5) ? cswc_pkg::CH_SPACE
                                    : 8'($urandom_range(8'h09, 8'h0D));
    while (!allow_nl && c == cswc_pkg::CH_NL);
    return c;
  endfunction

  task automatic add_word();
    repeat ($urandom_range(1, 8)) add_byte(plain_char());
  endtask

  task automatic add_blanks(input bit allow_nl);
    repeat ($urandom_range(1, 4)) add_byte(blank_char(allow_nl));
  endtask

  // A literal with random content and escapes, sometimes left unclosed.
  task automatic add_literal(input logic [7:0] quote);
    int pick;
    add_byte(quote);
    repeat ($urandom_range(0, 8)) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        add_byte(plain_char());
      end else if (pick < 90) begin
        add_byte(cswc_pkg::CH_BSLASH);
        add_byte(8'($urandom_range(255)));
      end else begin
        add_byte(8'($urandom_range(255)));
      end
    end
    pick = $urandom_range(99);
    if (pick < 85) add_byte(quote);
    else if (pick < 95) add_byte(cswc_pkg::CH_NL);
  endtask

  task automatic add_directive();
    add_byte(cswc_pkg::CH_HASH);
    if ($urandom_range(3) == 0) add_blanks(1'b0);
    add_word();
    add_blanks(1'b0);
    if ($urandom_range(2) == 0) add_literal(cswc_pkg::CH_DQUOTE);
    else add_word();
    if ($urandom_range(1)) add_blanks(1'b0);
    add_byte(cswc_pkg::CH_NL);
  endtask

  // Directed cases, then random C-like text with some noise.
  initial begin : stimulus
    logic [7:0] corner[] = '{
      8'h00, 8'h20, 8'h09, 8'h61,                 // a NUL byte, blanks, then a byte
      8'hFF, 8'h80, 8'h7F,                        // top byte is ordinary
      8'h23, 8'h64, 8'h20, 8'h0A,                 // header newline drops space
      8'h22, 8'h5C, 8'h22, 8'h20, 8'h0A,          // string, escaped quote, newline
      8'h27, 8'h5C, 8'h0A, 8'h27,                 // char literal, escaped newline
      8'h0B, 8'h0D, 8'h0C, 8'h78,                 // other blanks collapse
      8'h23, 8'h22, 8'h0A, 8'h0A, 8'h5C           // literal ends in a header line
    };
    int pick;
    src_n = 0;
    err_n = 0;
    foreach (corner[i]) add_byte(corner[i]);
    while (src_n < 2000) begin
      pick = $urandom_range(99);
      if (pick < 35) add_word();
      else if (pick < 60) add_blanks(1'b1);
      else if (pick < 72) add_literal(cswc_pkg::CH_DQUOTE);
      else if (pick < 80) add_literal(cswc_pkg::CH_SQUOTE);
      else if (pick < 90) add_directive();
      else add_byte(8'($urandom_range(255)));
    end

    // Wait for the last transfer, then for the output to drain.
    @(posedge rst_ni);
    do @(negedge clk_i); while (src_q.size() > 0 || in_valid);
    do @(negedge clk_i); while (due_q.size() > 0);
    repeat (20) @(negedge clk_i);
    if (err_n == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
